@@ design/sbd_pkg.sv @@
// Shared types and constants for the sectioned byte descrambler.
// Used by sbd_decode and sectioned_byte_descrambler; depends on nothing.
`default_nettype none

package sbd_pkg;

    // Number of header bytes that follow the key
    localparam logic [15:0] HEADER_BYTES = 16'd21;
    // Header xor base, ASCII 'K'
    localparam logic [7:0]  HDR_XOR_BASE = 8'h4B;

    // Section codes carried on the result
    localparam logic [2:0] SEC_KEY      = 3'd0;
    localparam logic [2:0] SEC_HEADER   = 3'd1;
    localparam logic [2:0] SEC_TEXT     = 3'd2;
    localparam logic [2:0] SEC_SETTINGS = 3'd3;
    localparam logic [2:0] SEC_CHECKSUM = 3'd4;

    // Status codes carried on the result
    localparam logic [1:0] ST_BUSY  = 2'd0;
    localparam logic [1:0] ST_GOOD  = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_EARLY = 2'd3;

    // Section of the file that the next byte belongs to
    typedef enum logic [1:0] {
        PH_KEY      = 2'd0,
        PH_HEADER   = 2'd1,
        PH_TEXT     = 2'd2,
        PH_SETTINGS = 2'd3
    } phase_t;

    // Input transaction
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } raw_t;

    // Result transaction
    typedef struct packed {
        logic [7:0]  plain_byte;
        logic [2:0]  section;
        logic [15:0] index;
        logic [1:0]  status;
        logic        done_res;
    } res_t;

    // Descrambler context carried from byte to byte
    typedef struct packed {
        phase_t      phase;
        logic [7:0]  key;
        logic [15:0] position;
        logic [7:0]  sum;
    } ctx_t;

endpackage

`default_nettype wire

@@ design/sbd_decode.sv @@
// Per-byte descramble logic: decodes one raw byte against the current context.
// Purely combinational; uses types and constants from sbd_pkg.
`default_nettype none

module sbd_decode (
    input  wire sbd_pkg::raw_t raw,
    input  wire sbd_pkg::ctx_t ctx,
    output sbd_pkg::res_t res,
    output sbd_pkg::ctx_t ctx_next
);

    logic [7:0]  b;
    logic [7:0]  p;
    logic [7:0]  hdr_plain;
    logic [7:0]  body_plain;
    logic [15:0] pos_inc;

    assign b       = raw.data_byte;
    assign p       = ctx.position[7:0];
    assign pos_inc = ctx.position + 16'd1;

    // Header rule: xor key, xor ('K' + pos), subtract pos, xor pos
    assign hdr_plain = (((b ^ ctx.key) ^ (sbd_pkg::HDR_XOR_BASE + p)) - p) ^ p;

    // Text line and settings rule: subtract key, xor pos, xor key
    assign body_plain = ((b - ctx.key) ^ p) ^ ctx.key;

    // Checksum update: sum = (sum ^ d) + d
    function automatic logic [7:0] accumulate(input logic [7:0] sum, input logic [7:0] d);
        return (sum ^ d) + d;
    endfunction

    always_comb
    begin
        res.plain_byte = b;
        res.section    = sbd_pkg::SEC_KEY;
        res.index      = 16'd0;
        res.status     = sbd_pkg::ST_BUSY;
        res.done_res   = raw.end_of_file;
        ctx_next       = ctx;

        if (raw.end_of_file)
        begin
            // Checksum byte; early end when settings were never reached
            res.section = sbd_pkg::SEC_CHECKSUM;
            if (ctx.phase == sbd_pkg::PH_SETTINGS)
            begin
                res.status = (b == ctx.sum) ? sbd_pkg::ST_GOOD : sbd_pkg::ST_BAD;
            end
            else
            begin
                res.status = sbd_pkg::ST_EARLY;
            end
            ctx_next.phase    = sbd_pkg::PH_KEY;
            ctx_next.key      = 8'd0;
            ctx_next.position = 16'd0;
            ctx_next.sum      = 8'd0;
        end
        else
        begin
            unique case (ctx.phase)
                sbd_pkg::PH_HEADER:
                begin
                    res.section       = sbd_pkg::SEC_HEADER;
                    res.index         = ctx.position;
                    res.plain_byte    = hdr_plain;
                    ctx_next.sum      = accumulate(ctx.sum, hdr_plain);
                    ctx_next.position = pos_inc;
                    if (pos_inc >= sbd_pkg::HEADER_BYTES)
                    begin
                        ctx_next.phase    = sbd_pkg::PH_TEXT;
                        ctx_next.position = 16'd0;
                    end
                end
                sbd_pkg::PH_TEXT:
                begin
                    res.section       = sbd_pkg::SEC_TEXT;
                    res.index         = ctx.position;
                    res.plain_byte    = body_plain;
                    ctx_next.sum      = accumulate(ctx.sum, body_plain);
                    ctx_next.position = pos_inc;
                    // Zero terminator closes the text line
                    if (body_plain == 8'd0)
                    begin
                        ctx_next.phase    = sbd_pkg::PH_SETTINGS;
                        ctx_next.position = 16'd0;
                    end
                end
                sbd_pkg::PH_SETTINGS:
                begin
                    res.section       = sbd_pkg::SEC_SETTINGS;
                    res.index         = ctx.position;
                    res.plain_byte    = body_plain;
                    ctx_next.sum      = accumulate(ctx.sum, body_plain);
                    ctx_next.position = pos_inc;
                end
                sbd_pkg::PH_KEY:
                begin
                    // Key byte starts a new file
                    ctx_next.key      = b;
                    ctx_next.sum      = 8'd0;
                    ctx_next.position = 16'd0;
                    ctx_next.phase    = sbd_pkg::PH_HEADER;
                end
                default:
                begin
                    ctx_next = ctx;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/sectioned_byte_descrambler.sv @@
// Top level of the sectioned byte descrambler: input register, context and result register.
// Depends on sbd_pkg and sbd_decode.
`default_nettype none

// Takes one scrambled file byte per transaction, starting after the identifier, and
// returns one result per byte: the decoded byte, its section, index and status.
// Throughput is one byte per clock cycle while the result side does not stall; a byte
// is captured in the input register when it is accepted and its result is presented
// from the result register, loaded when the byte leaves the input register. Each cycle
// the result side stalls holds the result there and, with the input register full, stalls
// the input. The figure is set by the single decode stage between the two registers, where
// the file context (section, key, position, checksum) is read and updated in the same
// cycle. The byte flagged end_of_file is the checksum; its result carries done_res and
// the context then returns to the key section, so the next byte starts a new file.
module sectioned_byte_descrambler (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    raw_valid,
    output logic         raw_stall,
    input  wire sbd_pkg::raw_t raw,
    output logic         res_valid,
    input  wire logic    res_stall,
    output sbd_pkg::res_t res
);

    logic           s1_valid_reg;
    sbd_pkg::raw_t  s1_reg;
    sbd_pkg::ctx_t  ctx_reg;
    sbd_pkg::ctx_t  ctx_next;
    sbd_pkg::res_t  res_next;
    logic           res_valid_reg;
    sbd_pkg::res_t  res_reg;
    logic           advance;
    logic           raw_take;

    // Flow control: input register moves on when the result register is free
    assign advance   = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign raw_stall = s1_valid_reg && !advance;
    assign raw_take  = raw_valid && !raw_stall;

    sbd_decode u_decode (
        .raw      (s1_reg),
        .ctx      (ctx_reg),
        .res      (res_next),
        .ctx_next (ctx_next)
    );

    // Control state: valid flags and file context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
            ctx_reg.phase    <= sbd_pkg::PH_KEY;
            ctx_reg.key      <= 8'd0;
            ctx_reg.position <= 16'd0;
            ctx_reg.sum      <= 8'd0;
        end
        else
        begin
            if (raw_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
                ctx_reg       <= ctx_next;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (raw_take)
        begin
            s1_reg <= raw;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // The checksum transaction sends the context back to the key section
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_reg.end_of_file |=> ctx_reg.phase == sbd_pkg::PH_KEY)
        else $error("context not reset after final byte");

    // Header position stays inside the header
    a_hdr_pos: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.phase == sbd_pkg::PH_HEADER |-> ctx_reg.position < sbd_pkg::HEADER_BYTES)
        else $error("header position out of range");

    // Checksum section exactly on the final result
    a_done_sec: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.done_res == (res.section == sbd_pkg::SEC_CHECKSUM)))
        else $error("done flag and checksum section disagree");

    // A final status only on the final result
    a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res.status != sbd_pkg::ST_BUSY) == res.done_res))
        else $error("status and done flag disagree");

    // Key and checksum results carry index zero
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.section == sbd_pkg::SEC_KEY || res.section == sbd_pkg::SEC_CHECKSUM)
        |-> res.index == 16'd0)
        else $error("nonzero index outside a counted section");

endmodule

`default_nettype wire

@@ test/sectioned_byte_descrambler_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sectioned_byte_descrambler: scripted and random files,
// scored against a behavioral descrambler. Depends on sbd_pkg and the design sources.

module sectioned_byte_descrambler_tb;

    localparam int RANDOM_BYTES = 1300;
    localparam int LONG_TEXT    = 300;
    localparam int STUCK_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    // How a scripted row is used
    localparam logic [1:0] ROW_FREE  = 2'd0;  // checked against the predictor
    localparam logic [1:0] ROW_TYPED = 2'd1;  // expected result written in the row
    localparam logic [1:0] ROW_SUM   = 2'd2;  // send the running checksum as the byte

    localparam sbd_pkg::res_t NONE = '0;

    typedef struct packed {
        logic [7:0]    data;
        logic          eof;
        logic [1:0]    how;
        sbd_pkg::res_t want;
    } script_row_t;

    // Early end on the very first byte, early end in the header, then a minimal
    // complete file: key FF, full header, text line holding only its terminator,
    // no settings, correct checksum.
    localparam script_row_t SCRIPT [0:27] = '{
        {8'hFF, 1'b1, ROW_TYPED,
            {8'hFF, sbd_pkg::SEC_CHECKSUM, 16'd0, sbd_pkg::ST_EARLY, 1'b1}},
        {8'h00, 1'b0, ROW_TYPED,
            {8'h00, sbd_pkg::SEC_KEY, 16'd0, sbd_pkg::ST_BUSY, 1'b0}},
        {8'hFF, 1'b0, ROW_FREE,  NONE},
        {8'h5A, 1'b1, ROW_TYPED,
            {8'h5A, sbd_pkg::SEC_CHECKSUM, 16'd0, sbd_pkg::ST_EARLY, 1'b1}},
        {8'hFF, 1'b0, ROW_TYPED,
            {8'hFF, sbd_pkg::SEC_KEY, 16'd0, sbd_pkg::ST_BUSY, 1'b0}},
        {8'h00, 1'b0, ROW_FREE,  NONE},
        {8'hFF, 1'b0, ROW_FREE,  NONE},
        {8'h55, 1'b0, ROW_FREE,  NONE},
        {8'hAA, 1'b0, ROW_FREE,  NONE},
        {8'h01, 1'b0, ROW_FREE,  NONE},
        {8'h80, 1'b0, ROW_FREE,  NONE},
        {8'h7F, 1'b0, ROW_FREE,  NONE},
        {8'hFE, 1'b0, ROW_FREE,  NONE},
        {8'h10, 1'b0, ROW_FREE,  NONE},
        {8'h20, 1'b0, ROW_FREE,  NONE},
        {8'h40, 1'b0, ROW_FREE,  NONE},
        {8'h08, 1'b0, ROW_FREE,  NONE},
        {8'h04, 1'b0, ROW_FREE,  NONE},
        {8'h02, 1'b0, ROW_FREE,  NONE},
        {8'hC3, 1'b0, ROW_FREE,  NONE},
        {8'h3C, 1'b0, ROW_FREE,  NONE},
        {8'h96, 1'b0, ROW_FREE,  NONE},
        {8'h69, 1'b0, ROW_FREE,  NONE},
        {8'hE7, 1'b0, ROW_FREE,  NONE},
        {8'h18, 1'b0, ROW_FREE,  NONE},
        {8'h4B, 1'b0, ROW_FREE,  NONE},
        {8'hFE, 1'b0, ROW_TYPED,
            {8'h00, sbd_pkg::SEC_TEXT, 16'd0, sbd_pkg::ST_BUSY, 1'b0}},
        {8'h00, 1'b1, ROW_SUM,   NONE}
    };

    logic clk;
    logic rst_n     = 1'b0;
    logic raw_valid = 1'b0;
    logic raw_stall;
    sbd_pkg::raw_t raw_in = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    sbd_pkg::res_t res_out;

    // Descrambler state as the testbench sees it
    sbd_pkg::phase_t cur_phase = sbd_pkg::PH_KEY;
    logic [7:0]      cur_key   = '0;
    logic [15:0]     cur_pos   = '0;
    logic [7:0]      cur_sum   = '0;

    sbd_pkg::res_t pending_results [$];
    sbd_pkg::res_t want_res;

    logic tx_gaps   = 1'b1;
    logic rx_stalls = 1'b1;
    int   bytes_sent  = 0;
    int   results_seen = 0;
    int   mismatches  = 0;
    int   n_good = 0, n_bad = 0, n_early = 0;
    int   deepest_index = 0;
    int   stuck_cycles = 0;

    sectioned_byte_descrambler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw_valid),
        .raw_stall (raw_stall),
        .raw       (raw_in),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Decode one byte and advance the file state
    function automatic sbd_pkg::res_t descramble_next(input sbd_pkg::raw_t item);
        sbd_pkg::res_t r;
        logic [7:0]    p;
        logic [7:0]    v;
        p = cur_pos[7:0];
        r.plain_byte = item.data_byte;
        r.section    = sbd_pkg::SEC_KEY;
        r.index      = '0;
        r.status     = sbd_pkg::ST_BUSY;
        r.done_res   = item.end_of_file;
        if (item.end_of_file)
        begin
            r.section = sbd_pkg::SEC_CHECKSUM;
            if (cur_phase == sbd_pkg::PH_SETTINGS)
                r.status = (item.data_byte == cur_sum) ? sbd_pkg::ST_GOOD : sbd_pkg::ST_BAD;
            else
                r.status = sbd_pkg::ST_EARLY;
            cur_phase = sbd_pkg::PH_KEY;
            cur_key   = '0;
            cur_pos   = '0;
            cur_sum   = '0;
        end
        else if (cur_phase == sbd_pkg::PH_KEY)
        begin
            cur_key   = item.data_byte;
            cur_sum   = '0;
            cur_pos   = '0;
            cur_phase = sbd_pkg::PH_HEADER;
        end
        else
        begin
            r.index = cur_pos;
            if (cur_phase == sbd_pkg::PH_HEADER)
            begin
                v = item.data_byte ^ cur_key ^ (sbd_pkg::HDR_XOR_BASE + p);
                v = (v - p) ^ p;
                r.section = sbd_pkg::SEC_HEADER;
            end
            else
            begin
                v = ((item.data_byte - cur_key) ^ p) ^ cur_key;
                r.section = (cur_phase == sbd_pkg::PH_TEXT) ? sbd_pkg::SEC_TEXT
                                                            : sbd_pkg::SEC_SETTINGS;
            end
            r.plain_byte = v;
            cur_sum = (cur_sum ^ v) + v;
            cur_pos = cur_pos + 16'd1;
            if (cur_phase == sbd_pkg::PH_HEADER && cur_pos >= sbd_pkg::HEADER_BYTES)
            begin
                cur_phase = sbd_pkg::PH_TEXT;
                cur_pos   = '0;
            end
            else if (cur_phase == sbd_pkg::PH_TEXT && v == 8'h00)
            begin
                cur_phase = sbd_pkg::PH_SETTINGS;
                cur_pos   = '0;
            end
        end
        return r;
    endfunction

    // Raw byte that decodes to the text line terminator at the current position
    function automatic logic [7:0] terminator_byte();
        return (cur_key ^ cur_pos[7:0]) + cur_key;
    endfunction

    // Random byte value
    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Send one byte; valid stays high after acceptance so the next byte can follow
    task automatic put_byte(input logic [7:0] b, input logic eof);
        int            gap;
        sbd_pkg::raw_t item;
        item.data_byte   = b;
        item.end_of_file = eof;
        gap = tx_gaps ? int'($urandom_range(0, 15)) : 0;
        if (gap > 0)
        begin
            raw_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        raw_valid <= 1'b1;
        raw_in    <= item;
        @(posedge clk);
        while (raw_stall !== 1'b0) @(posedge clk);
        pending_results.push_back(descramble_next(item));
        bytes_sent++;
    endtask

    // Mostly well-formed files; some end early in the key, header or text line
    task automatic send_file();
        int         ending;
        int         n_hdr;
        int         n_text;
        int         n_set;
        logic [7:0] b;
        ending = int'($urandom_range(0, 99));
        if (ending < 5)
        begin
            put_byte(rand_byte(), 1'b1);
            return;
        end
        put_byte(rand_byte(), 1'b0);
        n_hdr = (ending < 12) ? int'($urandom_range(0, int'(sbd_pkg::HEADER_BYTES) - 1))
                              : int'(sbd_pkg::HEADER_BYTES);
        repeat (n_hdr) put_byte(rand_byte(), 1'b0);
        if (ending < 12)
        begin
            put_byte(rand_byte(), 1'b1);
            return;
        end
        n_text = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 300))
                                             : int'($urandom_range(0, 20));
        repeat (n_text)
        begin
            b = rand_byte();
            if (b == terminator_byte())
                b = b ^ 8'h01;
            put_byte(b, 1'b0);
        end
        if (ending < 18)
        begin
            put_byte(rand_byte(), 1'b1);
            return;
        end
        put_byte(terminator_byte(), 1'b0);
        n_set = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 300))
                                            : int'($urandom_range(0, 24));
        repeat (n_set) put_byte(rand_byte(), 1'b0);
        b = ($urandom_range(0, 3) == 0) ? rand_byte() : cur_sum;
        put_byte(b, 1'b1);
    endtask

    // Stimulus
    initial
    begin
        script_row_t row;
        int          start;
        logic [7:0]  b;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCRIPT[i])
        begin
            row = SCRIPT[i];
            put_byte((row.how == ROW_SUM) ? cur_sum : row.data, row.eof);
            if (row.how == ROW_TYPED)
                pending_results[pending_results.size() - 1] = row.want;
        end

        // hold off until the scripted part has fully drained
        raw_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);

        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 12))
                    put_byte(rand_byte(), ($urandom_range(0, 15) == 0));
            else
                send_file();
        end

        // one file with a long text line, sent at full rate
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        put_byte(rand_byte(), 1'b0);
        repeat (sbd_pkg::HEADER_BYTES) put_byte(rand_byte(), 1'b0);
        repeat (LONG_TEXT)
        begin
            b = rand_byte();
            if (b == terminator_byte())
                b = b ^ 8'h80;
            put_byte(b, 1'b0);
        end
        put_byte(terminator_byte(), 1'b0);
        repeat (3) put_byte(rand_byte(), 1'b0);
        put_byte(cur_sum, 1'b1);

        raw_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d bytes: %0d good checksums, %0d bad, %0d files ended early",
                 bytes_sent, n_good, n_bad, n_early);
        $display("longest text line index %0d; sender gaps and result stalls of 0..15",
                 deepest_index);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Result side: stall a random number of cycles before taking each result
    initial
    begin
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = rx_stalls ? int'($urandom_range(0, 15)) : 0;
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            @(posedge clk);
            while (res_valid !== 1'b1) @(posedge clk);
        end
    end

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endfunction

    // Score every result transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with nothing expected, actual %p", $time, res_out);
            end
            else
            begin
                want_res = pending_results.pop_front();
                check_field("plain_byte", 16'(want_res.plain_byte), 16'(res_out.plain_byte));
                check_field("section", 16'(want_res.section), 16'(res_out.section));
                check_field("index", want_res.index, res_out.index);
                check_field("status", 16'(want_res.status), 16'(res_out.status));
                check_field("done_res", 16'(want_res.done_res), 16'(res_out.done_res));
                if (want_res.status == sbd_pkg::ST_GOOD)
                    n_good++;
                if (want_res.status == sbd_pkg::ST_BAD)
                    n_bad++;
                if (want_res.status == sbd_pkg::ST_EARLY)
                    n_early++;
                if (want_res.section == sbd_pkg::SEC_TEXT && int'(want_res.index) > deepest_index)
                    deepest_index = int'(want_res.index);
            end
        end
    end

    // Watchdog: cycles in a row with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((raw_valid === 1'b1 && raw_stall === 1'b0) ||
                (res_valid === 1'b1 && res_stall === 1'b0))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, STUCK_LIMIT, pending_results.size());
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule
